// ----- rtl/pidm_pkg.sv -----
// ----------------------------------------------------------------------------
// pidm_pkg
// shared types and constants for the multimode pid controller and its divider
// ----------------------------------------------------------------------------
package pidm_pkg;

    // divisor width of the shared divider (threshold, elapsed time)
    localparam int DEN_W = 31;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ----- rtl/pidm_div.sv -----
// ----------------------------------------------------------------------------
// pidm_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pidm_div #(
    parameter int W = 52
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [W-1:0]              dividend,
    input  logic [pidm_pkg::DEN_W-1:0] divisor,
    output pidm_pkg::div_stat_t       stat,
    output logic [W-1:0]              quotient
);
    import pidm_pkg::*;

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]     dvd_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   trial_sub;
    logic             fits;

    assign trial     = {rem_reg, dvd_reg[W-1]};
    assign trial_sub = trial - {1'b0, den_reg};
    assign fits      = (trial >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
            dvd_reg <= {dvd_reg[W-2:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = dvd_reg;

endmodule

// ----- rtl/pid_controller_multimode_unit.sv -----
// ----------------------------------------------------------------------------
// pid_controller_multimode_unit
// fixed-point pid controller with anti-windup, selectable integral and
// derivative modes, built around one shared multiplier and one serial divider
// ----------------------------------------------------------------------------
//
// channel | direction | handshake           | payload
// --------+-----------+---------------------+-------------------------------------
// s_      | in        | s_tvalid / s_tready | s_tdata, s_tuser (restart)
// m_      | out       | m_tvalid / m_tready | m_tdata (drive)
// cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one transaction on s_ gives one transaction on m_
// a restart goes straight to the output step; a normal one runs the trapezoid,
// derivative and drive steps, a held derivative skips the rate steps, and the
// separation and variable integral and the low-pass derivative add steps;
// DW = max(32 + FRAC_BITS, 52) is the divider width (one bit per cycle); the
// trapezoid step divides by 2e6 through a reciprocal product and a small fix-up
// s_tready is high only while the sequencer is idle; the result register
// frees it while the previous drive still waits on m_tready, and the output
// step waits only while an older drive is still unaccepted
// aresetn is synchronous and clears the controller history and config
//
module pid_controller_multimode_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [119:0] s_tdata,   // setpoint[31:0], feedback[63:32],
                                    // elapsed_us[83:64], feedforward[115:84], zero pad
    input  logic [0:0]   s_tuser,   // restart[0]
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,   // drive[31:0]
    // configuration writes
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [3:0]   cfg_index,
    input  logic [51:0]  cfg_data
);
    import pidm_pkg::*;

    // divider width: covers |e| shifted by the fraction and diff * 1e6
    localparam int DW = (32 + FRAC_BITS > 52) ? 32 + FRAC_BITS : 52;
    localparam int QW = DW + 1;
    localparam logic signed [65:0] FRAC_ADJ = (66'sd1 <<< FRAC_BITS) - 66'sd1;
    localparam logic signed [32:0] ONE      = 33'sd1 <<< FRAC_BITS;

    localparam logic [3:0] REG_GAIN_P     = 4'd0;
    localparam logic [3:0] REG_GAIN_I     = 4'd1;
    localparam logic [3:0] REG_GAIN_D     = 4'd2;
    localparam logic [3:0] REG_INT_LIMIT  = 4'd3;
    localparam logic [3:0] REG_OUT_LOWER  = 4'd4;
    localparam logic [3:0] REG_OUT_UPPER  = 4'd5;
    localparam logic [3:0] REG_MODE_WORD  = 4'd6;
    localparam logic [3:0] REG_INT_SHAPE  = 4'd7;

    localparam logic [1:0] IMODE_PLAIN = 2'd0;
    localparam logic [1:0] IMODE_SEP   = 2'd1;
    localparam logic [1:0] IMODE_VAR   = 2'd2;
    localparam logic [1:0] DMODE_MEAS  = 2'd1;
    localparam logic [1:0] DMODE_LP    = 2'd2;
    localparam logic [1:0] DMODE_HOLD  = 2'd3;

    localparam logic [19:0] TIMEOUT_US   = 20'd100000;
    localparam logic signed [32:0] US_PER_S = 33'sd1000000;

    // 2e6 = 2^7 * 15625; floor(2^45 / 15625) gives a quotient at most 2 low
    localparam logic signed [32:0] RCP_15625 = 33'sd2251799813;
    localparam logic signed [32:0] DIV_15625 = 33'sd15625;

    typedef enum logic [22:0] {
        ST_IDLE      = 23'd1,
        ST_INC_MUL   = 23'd1 << 1,
        ST_INC_RCP   = 23'd1 << 2,
        ST_INC_BACK  = 23'd1 << 3,
        ST_INC_FIX   = 23'd1 << 4,
        ST_RATIO_DIV = 23'd1 << 5,
        ST_SEP_MUL1  = 23'd1 << 6,
        ST_SEP_UPD1  = 23'd1 << 7,
        ST_SEP_MUL2  = 23'd1 << 8,
        ST_SEP_UPD2  = 23'd1 << 9,
        ST_Q_DIV     = 23'd1 << 10,
        ST_VAR_MUL   = 23'd1 << 11,
        ST_VAR_ADD   = 23'd1 << 12,
        ST_RATE_MUL  = 23'd1 << 13,
        ST_RATE_DIV  = 23'd1 << 14,
        ST_LP_MUL1   = 23'd1 << 15,
        ST_LP_MUL2   = 23'd1 << 16,
        ST_LP_FIN    = 23'd1 << 17,
        ST_DRV_P     = 23'd1 << 18,
        ST_DRV_I     = 23'd1 << 19,
        ST_DRV_D     = 23'd1 << 20,
        ST_DRV_FIN   = 23'd1 << 21,
        ST_OUT       = 23'd1 << 22
    } state_t;

    // configuration registers
    logic signed [31:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [30:0]        int_limit_reg, out_lower_reg, out_upper_reg, int_shape_reg;
    logic [51:0]        mode_word_reg;

    // controller history
    logic signed [31:0] isum_reg, prev_err_reg, deriv_reg, prev_deriv_reg;

    // sequencer and working registers
    state_t             state_reg, state_next;
    logic               started_reg;
    logic signed [31:0] e_reg, fb_reg, ff_reg, raw_reg, ratio_reg;
    logic [19:0]        us_reg;
    logic signed [65:0] prod_reg;
    logic signed [32:0] inc_reg, f_reg;
    logic signed [67:0] acc_reg;
    logic               m_tvalid_reg;
    logic [31:0]        m_tdata_reg;
    logic [44:0]        nabs_reg;
    logic               nneg_reg;
    logic [31:0]        qest_reg;

    // field views
    logic [1:0]         imode, dmode;
    logic [15:0]        lpa;
    logic signed [31:0] sep_gain;
    logic signed [31:0] in_sp, in_fb, in_ff;
    logic [19:0]        in_us;
    logic               in_restart, in_accept;
    logic signed [31:0] e_in;

    // shared multiplier
    logic signed [32:0] mul_a, mul_b;
    logic               mul_en;

    // shared divider
    logic               div_state, div_start, div_neg, div_zero, div_fin;
    logic [DW-1:0]      div_dividend, div_quot;
    logic [DEN_W-1:0]   div_divisor;
    div_stat_t          div_stat;
    logic signed [QW-1:0] div_q;

    logic [65:0]        abs_prod;
    logic [31:0]        mag_e;
    logic [DW-1:0]      mag_shift;
    logic signed [65:0] qt_prod;
    logic signed [32:0] diff;
    logic signed [32:0] inc_now;
    logic [45:0]        inc_rem;
    logic [1:0]         inc_corr;
    logic [32:0]        inc_mag;
    logic signed [QW:0] one_minus_q;
    logic signed [32:0] f_val;
    logic signed [31:0] raw_now, lp_now, isum_acc, isum_var, isum_hold;
    logic signed [67:0] drive_lo, drive_hi;
    logic [31:0]        drive_clamped;
    logic               sep_accum;
    state_t             deriv_entry;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [31:0] r;
        if (v > 68'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -68'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // fixed-point product back to scale, truncated toward zero
    function automatic logic signed [65:0] qtrunc(input logic signed [65:0] v);
        logic signed [65:0] adj;
        adj = v + ((v < 0) ? FRAC_ADJ : 66'sd0);
        return adj >>> FRAC_BITS;
    endfunction

    function automatic logic signed [67:0] trunc16(input logic signed [67:0] v);
        logic signed [67:0] adj;
        adj = v + ((v < 0) ? 68'sd65535 : 68'sd0);
        return adj >>> 16;
    endfunction

    function automatic logic signed [31:0] clamp_int(input logic signed [35:0] v,
                                                     input logic [30:0] lim);
        logic signed [35:0] l;
        logic signed [31:0] r;
        l = signed'({5'b0, lim});
        if (v > l) begin
            r = signed'({1'b0, lim});
        end else if (v < -l) begin
            r = 32'(-l);
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // field unpacking
    assign imode      = mode_word_reg[1:0];
    assign dmode      = mode_word_reg[3:2];
    assign lpa        = mode_word_reg[19:4];
    assign sep_gain   = signed'(mode_word_reg[51:20]);
    assign in_sp      = signed'(s_tdata[31:0]);
    assign in_fb      = signed'(s_tdata[63:32]);
    assign in_us      = s_tdata[83:64];
    assign in_ff      = signed'(s_tdata[115:84]);
    assign in_restart = s_tuser[0];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // error, saturated to 32 bits
    assign e_in = sat32(68'(33'(in_sp) - 33'(in_fb)));

    // configuration writes, unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg    <= '0;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            int_limit_reg <= '0;
            out_lower_reg <= '0;
            out_upper_reg <= '0;
            mode_word_reg <= '0;
            int_shape_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_GAIN_P:    gain_p_reg    <= signed'(cfg_data[31:0]);
                REG_GAIN_I:    gain_i_reg    <= signed'(cfg_data[31:0]);
                REG_GAIN_D:    gain_d_reg    <= signed'(cfg_data[31:0]);
                REG_INT_LIMIT: int_limit_reg <= cfg_data[30:0];
                REG_OUT_LOWER: out_lower_reg <= cfg_data[30:0];
                REG_OUT_UPPER: out_upper_reg <= cfg_data[30:0];
                REG_MODE_WORD: mode_word_reg <= cfg_data;
                REG_INT_SHAPE: int_shape_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // magnitudes and scaled terms
    assign abs_prod  = prod_reg[65] ? $unsigned(-prod_reg) : $unsigned(prod_reg);
    assign mag_e     = e_reg[31] ? 32'(-33'(e_reg)) : 32'(e_reg);
    assign mag_shift = DW'(mag_e) << FRAC_BITS;
    assign qt_prod   = qtrunc(prod_reg);
    assign diff      = (dmode == DMODE_MEAS) ? 33'(prev_err_reg) - 33'(fb_reg)
                                             : 33'(e_reg) - 33'(prev_err_reg);
    assign sep_accum = ({1'b0, mag_e} < {2'b0, int_shape_reg});

    // shared multiplier operand select
    always_comb begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (state_reg)
            ST_INC_MUL: begin
                mul_a = 33'(e_reg) + 33'(prev_err_reg);
                mul_b = signed'({13'b0, us_reg});
            end
            ST_INC_RCP: begin
                // |n| >> 20: the top bits of |n| / 128
                mul_a = signed'({1'b0, abs_prod[51:20]});
                mul_b = RCP_15625;
            end
            ST_INC_BACK: begin
                mul_a = signed'({1'b0, prod_reg[63:32]});
                mul_b = DIV_15625;
            end
            ST_SEP_MUL1: begin
                mul_a = 33'(e_reg);
                mul_b = 33'(ratio_reg);
            end
            ST_SEP_MUL2: begin
                mul_a = 33'(e_reg);
                mul_b = 33'(sep_gain);
            end
            ST_VAR_MUL: begin
                mul_a = inc_reg;
                mul_b = f_reg;
            end
            ST_RATE_MUL: begin
                mul_a = diff;
                mul_b = US_PER_S;
            end
            ST_LP_MUL1: begin
                mul_a = signed'(33'h10000 - {17'b0, lpa});
                mul_b = 33'(raw_reg);
            end
            ST_LP_MUL2: begin
                mul_a = signed'({17'b0, lpa});
                mul_b = 33'(prev_deriv_reg);
            end
            ST_DRV_P: begin
                mul_a = 33'(gain_p_reg);
                mul_b = 33'(e_reg);
            end
            ST_DRV_I: begin
                mul_a = 33'(gain_i_reg);
                mul_b = 33'(isum_reg);
            end
            ST_DRV_D: begin
                mul_a = 33'(gain_d_reg);
                mul_b = 33'(deriv_reg);
            end
            default: mul_en = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
    end

    // shared divider operand select
    always_comb begin
        div_state    = 1'b1;
        div_dividend = abs_prod[DW-1:0];
        div_divisor  = '0;
        div_neg      = prod_reg[65];
        case (state_reg)
            ST_RATE_DIV:  div_divisor = DEN_W'(us_reg);
            ST_RATIO_DIV: begin
                div_dividend = mag_shift;
                div_divisor  = int_shape_reg;
                div_neg      = 1'b0;
            end
            ST_Q_DIV: begin
                div_dividend = mag_shift;
                div_divisor  = int_shape_reg;
                div_neg      = e_reg[31];
            end
            default: div_state = 1'b0;
        endcase
    end

    // a zero divisor finishes at once with a zero quotient
    assign div_zero  = (div_divisor == '0);
    assign div_start = div_state && !started_reg && !div_zero;
    assign div_fin   = div_state && (div_zero || div_stat.done);
    assign div_q     = div_zero ? '0
                     : (div_neg ? -signed'({1'b0, div_quot}) : signed'({1'b0, div_quot}));

    pidm_div #(
        .W (DW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    // trapezoid step: estimated quotient plus up to three steps of fix-up
    assign inc_rem  = 46'(nabs_reg) - prod_reg[45:0];
    assign inc_corr = (inc_rem >= 46'd46875) ? 2'd3
                    : ((inc_rem >= 46'd31250) ? 2'd2
                    : ((inc_rem >= 46'd15625) ? 2'd1 : 2'd0));
    assign inc_mag  = {1'b0, qest_reg} + {31'b0, inc_corr};
    assign inc_now  = nneg_reg ? -signed'(inc_mag) : signed'(inc_mag);

    // integral candidates
    assign isum_acc    = clamp_int(36'(isum_reg) + 36'(inc_now), int_limit_reg);
    assign isum_hold   = clamp_int(36'(isum_reg), int_limit_reg);
    assign isum_var    = clamp_int(36'(isum_reg) + 36'(qt_prod), int_limit_reg);
    assign one_minus_q = (QW+1)'(ONE) - (QW+1)'(div_q);
    assign f_val       = (one_minus_q < 0) ? 33'sd0
                       : ((one_minus_q > (QW+1)'(ONE)) ? ONE : 33'(one_minus_q));

    // derivative candidates
    assign raw_now = sat32(68'(div_q));
    assign lp_now  = sat32(trunc16(acc_reg + 68'(prod_reg)));

    // drive limits
    assign drive_lo      = -signed'({37'b0, out_lower_reg});
    assign drive_hi      = signed'({37'b0, out_upper_reg});
    assign drive_clamped = (acc_reg < drive_lo) ? 32'(drive_lo)
                         : ((acc_reg > drive_hi) ? 32'(drive_hi) : 32'(acc_reg));

    assign deriv_entry = (dmode == DMODE_HOLD) ? ST_DRV_P : ST_RATE_MUL;

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    state_next = in_restart ? ST_OUT : ST_INC_MUL;
                end
            end
            ST_INC_MUL:  state_next = ST_INC_RCP;
            ST_INC_RCP:  state_next = ST_INC_BACK;
            ST_INC_BACK: state_next = ST_INC_FIX;
            ST_INC_FIX: begin
                case (imode)
                    IMODE_SEP: begin
                        if (sep_accum || !(sep_gain > 0)) begin
                            state_next = deriv_entry;
                        end else begin
                            state_next = ST_RATIO_DIV;
                        end
                    end
                    IMODE_VAR: state_next = ST_Q_DIV;
                    default:   state_next = deriv_entry;
                endcase
            end
            ST_RATIO_DIV: if (div_fin) state_next = ST_SEP_MUL1;
            ST_SEP_MUL1:  state_next = ST_SEP_UPD1;
            ST_SEP_UPD1:  state_next = ST_SEP_MUL2;
            ST_SEP_MUL2:  state_next = ST_SEP_UPD2;
            ST_SEP_UPD2:  state_next = deriv_entry;
            ST_Q_DIV:     if (div_fin) state_next = ST_VAR_MUL;
            ST_VAR_MUL:   state_next = ST_VAR_ADD;
            ST_VAR_ADD:   state_next = deriv_entry;
            ST_RATE_MUL:  state_next = ST_RATE_DIV;
            ST_RATE_DIV: begin
                if (div_fin) begin
                    state_next = (dmode == DMODE_LP) ? ST_LP_MUL1 : ST_DRV_P;
                end
            end
            ST_LP_MUL1:   state_next = ST_LP_MUL2;
            ST_LP_MUL2:   state_next = ST_LP_FIN;
            ST_LP_FIN:    state_next = ST_DRV_P;
            ST_DRV_P:     state_next = ST_DRV_I;
            ST_DRV_I:     state_next = ST_DRV_D;
            ST_DRV_D:     state_next = ST_DRV_FIN;
            ST_DRV_FIN:   state_next = ST_OUT;
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // control state and controller history
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            started_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            isum_reg       <= '0;
            prev_err_reg   <= '0;
            deriv_reg      <= '0;
            prev_deriv_reg <= '0;
        end else begin
            state_reg <= state_next;

            // divider launch flag for the current divide state
            if (div_fin) begin
                started_reg <= 1'b0;
            end else if (div_start) begin
                started_reg <= 1'b1;
            end

            // result register handshake
            if (state_reg == ST_OUT && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    // restart or a stale sample drops the history
                    if (in_accept && (in_restart || in_us > TIMEOUT_US)) begin
                        isum_reg       <= '0;
                        prev_err_reg   <= '0;
                        deriv_reg      <= '0;
                        prev_deriv_reg <= '0;
                    end
                end
                ST_INC_FIX: begin
                    case (imode)
                        IMODE_PLAIN: isum_reg <= isum_acc;
                        IMODE_SEP:   isum_reg <= sep_accum ? isum_acc : '0;
                        IMODE_VAR:   ;
                        default:     isum_reg <= isum_hold;
                    endcase
                end
                ST_VAR_ADD: isum_reg <= isum_var;
                ST_RATE_DIV: begin
                    if (div_fin) begin
                        prev_err_reg <= (dmode == DMODE_MEAS) ? fb_reg : e_reg;
                        if (dmode != DMODE_LP) begin
                            deriv_reg <= raw_now;
                        end
                    end
                end
                ST_LP_FIN: begin
                    deriv_reg      <= lp_now;
                    prev_deriv_reg <= lp_now;
                end
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    e_reg   <= e_in;
                    fb_reg  <= in_fb;
                    us_reg  <= in_us;
                    ff_reg  <= in_ff;
                    acc_reg <= '0;
                end
            end
            ST_INC_RCP: begin
                nabs_reg <= abs_prod[51:7];
                nneg_reg <= prod_reg[65];
            end
            ST_INC_BACK:  qest_reg <= prod_reg[63:32];
            ST_INC_FIX: begin
                inc_reg   <= inc_now;
                ratio_reg <= '0;
            end
            ST_RATIO_DIV: if (div_fin) ratio_reg <= raw_now;
            ST_SEP_UPD1:  e_reg <= sat32(68'(qt_prod));
            ST_SEP_UPD2:  e_reg <= sat32(68'(qt_prod));
            ST_Q_DIV:     if (div_fin) f_reg <= f_val;
            ST_RATE_DIV:  if (div_fin) raw_reg <= raw_now;
            ST_LP_MUL2:   acc_reg <= 68'(prod_reg);
            ST_DRV_I:     acc_reg <= 68'(qt_prod);
            ST_DRV_D:     acc_reg <= acc_reg + 68'(qt_prod);
            ST_DRV_FIN:   acc_reg <= acc_reg + 68'(qt_prod) + 68'(ff_reg);
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_reg <= drive_clamped;
                end
            end
            default: ;
        endcase
    end

    // checks
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while an item is in progress");

    a_result_from_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside the output step");

    a_div_not_reused: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider launched while busy");

endmodule
